>>> rtl/matrix4_multiply_macros.svh
// ----------------------------------------------------------------------------
// matrix4_multiply assertion macros
// shared concurrent assertion forms, clocked on clk and held off by rst_n
// ----------------------------------------------------------------------------
`ifndef MATRIX4_MULTIPLY_MACROS_SVH
`define MATRIX4_MULTIPLY_MACROS_SVH

// consequent checked in the same cycle
`define M4M_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define M4M_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/m4m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_pkg
// types and constants shared by the matrix multiplier, its mac unit and checker
// ----------------------------------------------------------------------------
package m4m_pkg;

    localparam int FUNC_W  = 2;
    localparam int COORD_W = 2;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VAL_W;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic signed [VAL_W-1:0] cell_value;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0]      out_col;
        logic [COORD_W-1:0]      out_row;
        logic signed [VAL_W-1:0] product_value;
        logic                    last;
    } rsp_t;

    typedef struct packed {
        logic vld;
        logic first;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> rtl/m4m_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_mac
// shared multiply-accumulate unit: registered 32x32 product, wide accumulator
// ----------------------------------------------------------------------------
module m4m_mac
    import m4m_pkg::*;
#(
    parameter int ACC_W = 66
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [VAL_W-1:0] opa,
    input  logic signed [VAL_W-1:0] opb,
    output logic                    busy,
    output logic signed [ACC_W-1:0] acc
);

    mac_ctl_t                 mul_ctl_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  product_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctl_reg <= '0;
        end
        else
        begin
            mul_ctl_reg <= ctl;
        end
    end

    assign product_ext = ACC_W'(product_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (mul_ctl_reg.vld)
        begin
            acc_next = mul_ctl_reg.first ? product_ext : acc_reg + product_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(opa) * PROD_W'(opb);
        acc_reg     <= acc_next;
    end

    assign busy = mul_ctl_reg.vld;
    assign acc  = acc_reg;

endmodule

>>> rtl/matrix4_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply
// fixed-point DIM x DIM matrix multiplier with one shared multiply-accumulate
// ----------------------------------------------------------------------------
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one transaction per item:
//   load a cell of A, load a cell of B, or compute. After a load the block is
//   ready again in the next cycle; loads outside the matrix and unused func
//   codes are dropped.
//   A compute transaction streams DIM*DIM cells on the rsp channel
//   (rsp_valid / rsp_stall / rsp), x outer, y inner, last flagged on the final
//   cell. Each cell runs DIM multiply-accumulates through the single mac unit,
//   with read, multiply, drain and output load around them. cmd_stall stays
//   high for the whole compute.
//   The rsp register parts the two sides: a held result does not block new
//   loads, and while rsp_stall is high the sequencer waits before loading the
//   next cell, so nothing is lost.
//   Reset clears both matrices through per-cell valid bits, empties the
//   output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module matrix4_multiply
    import m4m_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CELLS  = DIM * DIM;
    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ACC_W  = PROD_W + $clog2(DIM);
    localparam int HI_LSB = FRAC_W + VAL_W - 1;
    localparam logic [ADDR_W-1:0] DIM_A    = ADDR_W'(DIM);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DIM - 1);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0] y_reg, y_next;
    logic [IDX_W-1:0] i_reg, i_next;

    logic signed [VAL_W-1:0] a_mem [CELLS];
    logic signed [VAL_W-1:0] b_mem [CELLS];
    logic [CELLS-1:0]        a_vld_reg;
    logic [CELLS-1:0]        b_vld_reg;
    logic signed [VAL_W-1:0] a_data_reg;
    logic signed [VAL_W-1:0] b_data_reg;
    logic                    a_hit_reg;
    logic                    b_hit_reg;
    mac_ctl_t                rd_ctl_reg;

    rsp_t rsp_reg;
    logic rsp_valid_reg;

    logic                    cmd_accept;
    logic                    in_range;
    logic                    wr_a;
    logic                    wr_b;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_a_addr;
    logic [ADDR_W-1:0]       rd_b_addr;
    logic signed [VAL_W-1:0] opa;
    logic signed [VAL_W-1:0] opb;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-HI_LSB-1:0] acc_hi;
    logic signed [VAL_W-1:0] sat_value;
    logic                    rsp_free;
    logic                    rsp_load;
    logic                    cell_last;

    // command side
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign in_range   = (int'(cmd.col) < DIM) && (int'(cmd.row) < DIM);
    assign wr_addr    = ADDR_W'(cmd.col) * DIM_A + ADDR_W'(cmd.row);
    assign wr_a       = cmd_accept && (cmd.func == FUNC_LOAD_A) && in_range;
    assign wr_b       = cmd_accept && (cmd.func == FUNC_LOAD_B) && in_range;

    assign rd_a_addr = ADDR_W'(i_reg) * DIM_A + ADDR_W'(y_reg);
    assign rd_b_addr = ADDR_W'(x_reg) * DIM_A + ADDR_W'(i_reg);

    // matrix stores
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[wr_addr] <= cmd.cell_value;
        end
        if (wr_b)
        begin
            b_mem[wr_addr] <= cmd.cell_value;
        end
        a_data_reg <= a_mem[rd_a_addr];
        b_data_reg <= b_mem[rd_b_addr];
        a_hit_reg  <= a_vld_reg[rd_a_addr];
        b_hit_reg  <= b_vld_reg[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end
        else
        begin
            if (wr_a)
            begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_b)
            begin
                b_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign opa = a_hit_reg ? a_data_reg : '0;
    assign opb = b_hit_reg ? b_data_reg : '0;

    m4m_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rd_ctl_reg),
        .opa   (opa),
        .opb   (opb),
        .busy  (mac_busy),
        .acc   (acc)
    );

    // truncate to q16.16 and saturate
    assign acc_hi = acc[ACC_W-1:HI_LSB];

    always_comb
    begin
        sat_value = acc[HI_LSB:FRAC_W];
        if ((acc_hi != '0) && (acc_hi != '1))
        begin
            sat_value = acc[ACC_W-1] ? VAL_MIN : VAL_MAX;
        end
    end

    // sequencer
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cell_last = (x_reg == LAST_IDX) && (y_reg == LAST_IDX);
    assign rsp_load  = (state_reg == ST_EMIT) && rsp_free;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        i_next     = i_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept && (cmd.func == FUNC_COMPUTE))
                begin
                    state_next = ST_ISSUE;
                    x_next     = '0;
                    y_next     = '0;
                    i_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_ctl_reg.vld && !mac_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    if (cell_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (y_reg == LAST_IDX)
                        begin
                            y_next = '0;
                            x_next = x_reg + 1'b1;
                        end
                        else
                        begin
                            y_next = y_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            i_reg         <= '0;
            rd_ctl_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            x_reg            <= x_next;
            y_reg            <= y_next;
            i_reg            <= i_next;
            rd_ctl_reg.vld   <= (state_reg == ST_ISSUE);
            rd_ctl_reg.first <= (i_reg == '0);
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.out_col       <= COORD_W'(x_reg);
            rsp_reg.out_row       <= COORD_W'(y_reg);
            rsp_reg.product_value <= sat_value;
            rsp_reg.last          <= cell_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/m4m_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_checker
// port-level checks of the matrix multiplier, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix4_multiply_macros.svh"

module m4m_checker
    import m4m_pkg::*;
#(
    parameter int DIM = 4
)
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input cmd_t cmd,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(DIM - 1);

    `M4M_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp transaction changed while stalled")
    `M4M_ASSERT_NEXT(a_compute_busy, cmd_valid && !cmd_stall && (cmd.func == FUNC_COMPUTE), cmd_stall, "compute did not stall the cmd channel")
    `M4M_ASSERT_NEXT(a_load_ready, cmd_valid && !cmd_stall && (cmd.func != FUNC_COMPUTE), !cmd_stall, "load left the cmd channel stalled")
    `M4M_ASSERT_SAME(a_last_corner, rsp_valid && rsp.last, (rsp.out_col == LAST_COORD) && (rsp.out_row == LAST_COORD), "last flag off the final cell")

endmodule

bind matrix4_multiply m4m_checker #(.DIM(DIM)) u_m4m_checker (.*);
